// ===== rtl/fva_pkg.sv =====
// fva_pkg: shared types and constants for the fixed_vector_to_angle block
// depends on nothing; used by fva_prep, fva_div_cell and fixed_vector_to_angle
`timescale 1ns / 1ps

package fva_pkg;

  localparam int MagBits      = 32;
  localparam int QuoBits      = 17;
  localparam int DivCells     = QuoBits;
  localparam int HeadingBits  = 14;
  localparam int HeadingShift = 5;
  localparam int ValueBits    = HeadingBits + HeadingShift;

  localparam logic [QuoBits-1:0]   FixOne   = QuoBits'(65536);
  localparam logic [ValueBits-1:0] FixTwo   = ValueBits'(131072);

  // one beat travelling down the divider chain
  typedef struct packed {
    logic                vld;
    logic                zero;
    logic                den_zero;
    logic [2:0]          octant;
    logic [MagBits:0]    rem;
    logic [MagBits-1:0]  den;
    logic [QuoBits-1:0]  quo;
  } fva_div_t;

endpackage

// ===== rtl/fva_prep.sv =====
// fva_prep: two register stages that form magnitudes, octant and the divide operands
// depends on fva_pkg
`timescale 1ns / 1ps

module fva_prep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic signed [fva_pkg::MagBits-1:0] dx,
  input  logic signed [fva_pkg::MagBits-1:0] dz,
  output fva_pkg::fva_div_t             div_out
);

  logic                        s1_vld;
  logic                        s1_zero;
  logic                        s1_xneg;
  logic                        s1_zneg;
  logic [fva_pkg::MagBits-1:0] s1_mx;
  logic [fva_pkg::MagBits-1:0] s1_mz;

  logic                        differ;
  logic                        lt;
  logic [2:0]                  octant;
  logic [2:0]                  oct_m1;
  logic [fva_pkg::MagBits-1:0] num;
  logic [fva_pkg::MagBits-1:0] den;

  // stage 1: signs and magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_zero <= (dx == '0) && (dz == '0);
      s1_xneg <= dx[fva_pkg::MagBits-1];
      s1_zneg <= dz[fva_pkg::MagBits-1];
      s1_mx   <= dx[fva_pkg::MagBits-1] ? ('0 - dx) : dx;
      s1_mz   <= dz[fva_pkg::MagBits-1] ? ('0 - dz) : dz;
    end
  end

  // stage 2: octant and operand swap
  always_comb begin
    differ = s1_xneg ^ s1_zneg;
    lt     = s1_mx < s1_mz;
    octant = {s1_zneg, differ, (lt ? ~differ : differ)};
    oct_m1 = octant - 3'd1;
    if (oct_m1[1]) begin
      num = s1_mz;
      den = s1_mx;
    end else begin
      num = s1_mx;
      den = s1_mz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_out.vld <= 1'b0;
    end else if (en) begin
      div_out.vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_out.zero     <= s1_zero;
      div_out.den_zero <= (den == '0);
      div_out.octant   <= octant;
      div_out.rem      <= {1'b0, num};
      div_out.den      <= den;
      div_out.quo      <= '0;
    end
  end

endmodule

// ===== rtl/fva_div_cell.sv =====
// fva_div_cell: one restoring-division cell, yields one quotient bit per beat
// depends on fva_pkg
`timescale 1ns / 1ps

module fva_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              shift,
  input  fva_pkg::fva_div_t div_in,
  output fva_pkg::fva_div_t div_out
);

  logic [fva_pkg::MagBits:0] trial;
  logic                      q_bit;
  logic [fva_pkg::MagBits:0] rem_next;

  always_comb begin
    trial    = shift ? {div_in.rem[fva_pkg::MagBits-1:0], 1'b0} : div_in.rem;
    q_bit    = trial >= {1'b0, div_in.den};
    rem_next = q_bit ? (trial - {1'b0, div_in.den}) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_out.vld <= 1'b0;
    end else if (en) begin
      div_out.vld <= div_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_out.zero     <= div_in.zero;
      div_out.den_zero <= div_in.den_zero;
      div_out.octant   <= div_in.octant;
      div_out.rem      <= rem_next;
      div_out.den      <= div_in.den;
      div_out.quo      <= {div_in.quo[fva_pkg::QuoBits-2:0], q_bit};
    end
  end

endmodule

// ===== rtl/fixed_vector_to_angle.sv =====
// fixed_vector_to_angle: 14-bit heading of a signed 16.16 vector
// depends on fva_pkg, fva_prep and fva_div_cell
`timescale 1ns / 1ps
//
// usage:
//   input channel: in_valid / in_ready with delta_x, delta_z (signed 16.16)
//   output channel: out_valid / out_ready with heading (0..16383, up is 0)
//   a zero vector gives heading 0
//   one beat in and one beat out per clock when the receiver keeps up
//   an accepted beat passes the two front stages, the 17-cell divider
//   chain (one quotient bit per cell) and the output register before
//   it reaches out_valid
//   the chain advances while the skid register is empty; a stalled result
//   sits in the output register and one more beat lands in the skid
//   register, after which in_ready drops until the receiver takes a beat
//   reset (rst, synchronous) empties the chain, the output and the skid
//
module fixed_vector_to_angle (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [fva_pkg::MagBits-1:0]     delta_x,
  input  logic signed [fva_pkg::MagBits-1:0]     delta_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [fva_pkg::HeadingBits-1:0]        heading
);

  fva_pkg::fva_div_t chain [fva_pkg::DivCells+1];

  logic                                en;
  logic                                skid_valid;
  logic [fva_pkg::HeadingBits-1:0]     skid_heading;
  logic [fva_pkg::QuoBits-1:0]         q;
  logic [fva_pkg::ValueBits-1:0]       r;
  logic [fva_pkg::ValueBits-1:0]       value;
  logic [fva_pkg::HeadingBits-1:0]     tail_heading;
  logic                                tail_take;

  assign en       = !skid_valid;
  assign in_ready = en;

  fva_prep u_prep (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_valid && in_ready),
    .dx      (delta_x),
    .dz      (delta_z),
    .div_out (chain[0])
  );

  for (genvar i = 0; i < fva_pkg::DivCells; i++) begin : g_cell
    fva_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .shift   ((i == 0) ? 1'b0 : 1'b1),
      .div_in  (chain[i]),
      .div_out (chain[i+1])
    );
  end

  // heading from octant and ratio
  always_comb begin
    q = chain[fva_pkg::DivCells].den_zero ? '0 : chain[fva_pkg::DivCells].quo;
    if (chain[fva_pkg::DivCells].octant[0]) begin
      r = fva_pkg::ValueBits'(fva_pkg::FixOne) - fva_pkg::ValueBits'(q);
    end else begin
      r = fva_pkg::ValueBits'(q);
    end
    value = fva_pkg::FixTwo - {chain[fva_pkg::DivCells].octant, 16'b0} - r;
    tail_heading = chain[fva_pkg::DivCells].zero ? '0
                 : value[fva_pkg::ValueBits-1:fva_pkg::HeadingShift];
    tail_take = chain[fva_pkg::DivCells].vld && en;
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= tail_take;
        end
      end else if (tail_take) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        heading <= skid_heading;
      end else if (tail_take) begin
        heading <= tail_heading;
      end
    end else if (tail_take) begin
      skid_heading <= tail_heading;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid filled without a stalled output");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    (chain[fva_pkg::DivCells].vld && !chain[fva_pkg::DivCells].den_zero)
      |-> (chain[fva_pkg::DivCells].quo <= fva_pkg::FixOne))
    else $error("ratio above one");
`endif

endmodule
